>>> src/scale2x_upscaler_assert.svh
// ----------------------------------------------------------------------------
// scale2x upscaler assertion macros
// shared concurrent assertion forms for the upscaler modules
// ----------------------------------------------------------------------------
`ifndef SCALE2X_UPSCALER_ASSERT_SVH
`define SCALE2X_UPSCALER_ASSERT_SVH

// same-cycle implication, off while reset is low
`define SCL2X_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scl2x assertion failed (same cycle)");

// next-cycle implication, off while reset is low
`define SCL2X_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scl2x assertion failed (next cycle)");

`endif

>>> src/scl2x_pkg.sv
// ----------------------------------------------------------------------------
// scl2x_pkg
// types and constants shared by the scale2x upscaler modules
// ----------------------------------------------------------------------------
package scl2x_pkg;

    localparam int PIX_W       = 32;
    localparam int POS_W       = 9;
    localparam int CFG_W       = 10;
    localparam int ADDR_W      = 3;
    localparam int APB_W       = 32;
    localparam int LINE_ROWS   = 3;
    localparam int SLOT_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int LVL_W       = 3;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd200;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [POS_W-1:0] t_pos;

    // one classified source pixel with every neighbour its blocks need
    typedef struct packed {
        t_pix cur;
        t_pix c1;
        t_pix c2;
        t_pix p1l;
        t_pix p1c;
        t_pix p1r;
        t_pix p2c;
        t_pos row;
        t_pos col;
        logic row_nz;
        logic has_a;
        logic has_l;
        logic has_s;
    } t_job;

endpackage

>>> src/scl2x_fifo.sv
// ----------------------------------------------------------------------------
// scl2x_fifo
// short job queue between the classify front and the block back end
// ----------------------------------------------------------------------------
`include "scale2x_upscaler_assert.svh"

module scl2x_fifo
    import scl2x_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_job             i_job,
    input  logic             i_pop,
    output t_job             o_head,
    output logic             o_empty,
    output logic [LVL_W-1:0] o_level
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  n_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + LVL_W'(1);
        end else if (!i_push && i_pop) begin
            n_level = r_level - LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_level == '0);
    assign o_level = r_level;

    `SCL2X_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, r_level == LVL_W'(QUEUE_DEPTH), !i_push)
    `SCL2X_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, r_level == '0, !i_pop)

endmodule

>>> src/scl2x_front.sv
// ----------------------------------------------------------------------------
// scl2x_front
// accepts source pixels, keeps position and line store, gathers neighbours
// ----------------------------------------------------------------------------
module scl2x_front
    import scl2x_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_frame_width,
    input  logic [CFG_W-1:0] i_frame_height,
    input  logic             i_restart,
    input  logic             i_pixel_valid,
    output logic             o_pixel_ready,
    input  t_pix             i_pixel,
    input  logic [LVL_W-1:0] i_level,
    output logic             o_push,
    output t_job             o_job
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CW-1:0]     last_col;
    logic [RW-1:0]     last_row;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     rd_col;
    logic [SLOT_W-1:0] r_slot_cur;
    logic [SLOT_W-1:0] r_slot_p1;
    logic [SLOT_W-1:0] r_slot_p2;
    logic              accept;
    logic              row_end;

    t_pix              r_line_mem [LINE_ROWS][MAX_WIDTH];
    t_pix              r_rd_up;
    t_pix              r_rd_up2;

    logic              r_f1_valid;
    t_pix              r_f1_pixel;
    logic              r_f1_col_zero;
    logic              r_f1_col_gt1;
    logic              r_f1_row_nz;
    logic              r_f1_row_gt1;
    logic              r_f1_has_a;
    logic              r_f1_has_l;
    logic              r_f1_has_s;
    t_pos              r_f1_row;
    t_pos              r_f1_col;

    t_pix              r_p1l;
    t_pix              r_p1c;
    t_pix              r_p1r;
    t_pix              r_prev1;
    t_pix              r_prev2;
    t_pix              r_first_row;
    t_pix              n_p1l;
    t_pix              n_p1c;
    t_pix              n_p1r;
    t_pix              c1;
    t_pix              c2;
    t_pix              p2c;

    // effective frame size, zero counts as one, large values saturate
    always_comb begin
        if (i_frame_width == '0) begin
            last_col = '0;
        end else if (32'(i_frame_width) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(i_frame_width - CFG_W'(1));
        end
        if (i_frame_height == '0) begin
            last_row = '0;
        end else if (32'(i_frame_height) > MAX_HEIGHT) begin
            last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row = RW'(i_frame_height - CFG_W'(1));
        end
    end

    assign o_pixel_ready = (i_level + LVL_W'(r_f1_valid)) < LVL_W'(QUEUE_DEPTH);
    assign accept        = i_pixel_valid && o_pixel_ready;
    assign row_end       = (r_col == last_col);
    assign rd_col        = row_end ? r_col : r_col + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= (r_row == last_row) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // three rotating line slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cur <= SLOT_W'(0);
            r_slot_p1  <= SLOT_W'(1);
            r_slot_p2  <= SLOT_W'(2);
        end else if (accept && row_end) begin
            r_slot_cur <= r_slot_p2;
            r_slot_p1  <= r_slot_cur;
            r_slot_p2  <= r_slot_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_mem[r_slot_cur][r_col] <= i_pixel;
            r_rd_up                       <= r_line_mem[r_slot_p1][rd_col];
            r_rd_up2                      <= r_line_mem[r_slot_p2][r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_pixel    <= i_pixel;
            r_f1_col_zero <= (r_col == '0);
            r_f1_col_gt1  <= (r_col > CW'(1));
            r_f1_row_nz   <= (r_row != '0);
            r_f1_row_gt1  <= (r_row > RW'(1));
            r_f1_has_a    <= (r_row != '0);
            r_f1_has_l    <= (r_row == last_row) && (r_col != '0);
            r_f1_has_s    <= (r_row == last_row) && row_end;
            r_f1_row      <= POS_W'(r_row);
            r_f1_col      <= POS_W'(r_col);
        end
    end

    // sliding windows over the row above and the current row
    always_comb begin
        if (r_f1_col_zero) begin
            n_p1l = r_first_row;
            n_p1c = r_first_row;
        end else begin
            n_p1l = r_p1c;
            n_p1c = r_p1r;
        end
        n_p1r = r_rd_up;
        c1    = r_f1_col_zero ? r_f1_pixel : r_prev1;
        c2    = r_f1_col_gt1 ? r_prev2 : c1;
        p2c   = r_f1_row_gt1 ? r_rd_up2 : n_p1c;
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_valid) begin
            r_p1l   <= n_p1l;
            r_p1c   <= n_p1c;
            r_p1r   <= n_p1r;
            r_prev2 <= r_prev1;
            r_prev1 <= r_f1_pixel;
            if (r_f1_col_zero) begin
                r_first_row <= r_f1_pixel;
            end
        end
    end

    assign o_push = r_f1_valid && (r_f1_has_a || r_f1_has_l || r_f1_has_s);

    always_comb begin
        o_job.cur    = r_f1_pixel;
        o_job.c1     = c1;
        o_job.c2     = c2;
        o_job.p1l    = n_p1l;
        o_job.p1c    = n_p1c;
        o_job.p1r    = n_p1r;
        o_job.p2c    = p2c;
        o_job.row    = r_f1_row;
        o_job.col    = r_f1_col;
        o_job.row_nz = r_f1_row_nz;
        o_job.has_a  = r_f1_has_a;
        o_job.has_l  = r_f1_has_l;
        o_job.has_s  = r_f1_has_s;
    end

endmodule

>>> src/scl2x_back.sv
// ----------------------------------------------------------------------------
// scl2x_back
// applies the edge rules to each queued block and drives the result register
// ----------------------------------------------------------------------------
`include "scale2x_upscaler_assert.svh"

module scl2x_back
    import scl2x_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_empty,
    output logic o_pop,
    output logic o_blk_valid,
    input  logic i_blk_ready,
    output t_pix o_top_left,
    output t_pix o_top_right,
    output t_pix o_bottom_left,
    output t_pix o_bottom_right,
    output t_pos o_src_col,
    output t_pos o_src_row,
    output logic o_last_of_run,
    output logic o_frame_done
);

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_L = 2'd1;
    localparam logic [1:0] SEL_S = 2'd2;

    localparam logic [2:0] MASK_A = 3'b001;
    localparam logic [2:0] MASK_L = 3'b010;
    localparam logic [2:0] MASK_S = 3'b100;

    typedef struct packed {
        t_pix e0;
        t_pix e1;
        t_pix e2;
        t_pix e3;
    } t_quad;

    function automatic t_quad scale_rule(input t_pix e, input t_pix b, input t_pix d,
                                         input t_pix f, input t_pix h);
        t_quad q;
        q.e0 = (d == b && b != f && d != h) ? d : e;
        q.e1 = (b == f && b != d && f != h) ? f : e;
        q.e2 = (d == h && d != b && h != f) ? d : e;
        q.e3 = (h == f && d != h && b != f) ? f : e;
        return q;
    endfunction

    logic [2:0] r_done;
    logic [2:0] head_flags;
    logic [2:0] pending;
    logic [2:0] sel_mask;
    logic [1:0] sel;
    logic       last;
    logic       load;
    t_pix       e;
    t_pix       b;
    t_pix       d;
    t_pix       f;
    t_pix       h;
    t_pos       pos_row;
    t_pos       pos_col;
    t_quad      quad;
    logic       r_valid;

    assign head_flags = {i_job.has_s, i_job.has_l, i_job.has_a};
    assign pending    = head_flags & ~r_done;

    always_comb begin
        priority if (pending[0]) begin
            sel = SEL_A;
        end else if (pending[1]) begin
            sel = SEL_L;
        end else begin
            sel = SEL_S;
        end
    end

    // block above, block to the left, block itself
    always_comb begin
        unique case (sel)
            SEL_A: begin
                sel_mask = MASK_A;
                e        = i_job.p1c;
                b        = i_job.p2c;
                d        = i_job.p1l;
                f        = i_job.p1r;
                h        = i_job.cur;
                pos_row  = i_job.row - POS_W'(1);
                pos_col  = i_job.col;
            end
            SEL_L: begin
                sel_mask = MASK_L;
                e        = i_job.c1;
                b        = i_job.row_nz ? i_job.p1l : i_job.c1;
                d        = i_job.c2;
                f        = i_job.cur;
                h        = i_job.c1;
                pos_row  = i_job.row;
                pos_col  = i_job.col - POS_W'(1);
            end
            SEL_S: begin
                sel_mask = MASK_S;
                e        = i_job.cur;
                b        = i_job.row_nz ? i_job.p1c : i_job.cur;
                d        = i_job.c1;
                f        = i_job.cur;
                h        = i_job.cur;
                pos_row  = i_job.row;
                pos_col  = i_job.col;
            end
            default: begin
                sel_mask = MASK_S;
                e        = i_job.cur;
                b        = i_job.cur;
                d        = i_job.cur;
                f        = i_job.cur;
                h        = i_job.cur;
                pos_row  = i_job.row;
                pos_col  = i_job.col;
            end
        endcase
    end

    assign quad  = scale_rule(e, b, d, f, h);
    assign last  = ((pending & ~sel_mask) == '0);
    assign load  = !i_empty && (!r_valid || i_blk_ready);
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= last ? '0 : (r_done | sel_mask);
            end else if (i_blk_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_top_left     <= quad.e0;
            o_top_right    <= quad.e1;
            o_bottom_left  <= quad.e2;
            o_bottom_right <= quad.e3;
            o_src_col      <= pos_col;
            o_src_row      <= pos_row;
            o_last_of_run  <= last;
            o_frame_done   <= (sel == SEL_S);
        end
    end

    assign o_blk_valid = r_valid;

    `SCL2X_ASSERT_IMPL(a_done_in_head, i_clk, i_rst_n, !i_empty, (r_done & ~head_flags) == '0)
    `SCL2X_ASSERT_NEXT(a_pop_clears, i_clk, i_rst_n, o_pop, r_done == '0)

endmodule

>>> src/scale2x_upscaler.sv
// the completing pixel goes via the f1 registers and job queue into the result register
// throughput: one source pixel per cycle with queue room, one block out per cycle if ready
// final row: up to two blocks per pixel, up to three on the last, input waits on queue room
// a 4-entry job queue between front and back absorbs output stalls
// reset: position counters to zero, width 320, height 200, line store left as is
// ----------------------------------------------------------------------------
// scale2x_upscaler
// streaming 2x edge-preserving upscaler with an apb register port
// ----------------------------------------------------------------------------
module scale2x_upscaler
    import scl2x_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    input  logic              i_pixel_valid,
    output logic              o_pixel_ready,
    input  t_pix              i_pixel,
    output logic              o_blk_valid,
    input  logic              i_blk_ready,
    output t_pix              o_top_left,
    output t_pix              o_top_right,
    output t_pix              o_bottom_left,
    output t_pix              o_bottom_right,
    output t_pos              o_src_col,
    output t_pos              o_src_row,
    output logic              o_last_of_run,
    output logic              o_frame_done
);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             cfg_write;
    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic [LVL_W-1:0] q_level;
    t_job             q_in;
    t_job             q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    scl2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_restart      (cfg_write),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .i_pixel        (i_pixel),
        .i_level        (q_level),
        .o_push         (q_push),
        .o_job          (q_in)
    );

    scl2x_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_level (q_level)
    );

    scl2x_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (q_head),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_blk_valid    (o_blk_valid),
        .i_blk_ready    (i_blk_ready),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_src_col      (o_src_col),
        .o_src_row      (o_src_row),
        .o_last_of_run  (o_last_of_run),
        .o_frame_done   (o_frame_done)
    );

endmodule

>>> dv/scale2x_upscaler_test.sv
// ----------------------------------------------------------------------------
// scale2x_upscaler_test
// streams source pixels into the upscaler under random handshake gaps and
// checks every 2x2 block against a cycle-free prediction of the scale2x rules,
// with frame geometry reprogrammed over the register port between runs
// ----------------------------------------------------------------------------
module scale2x_upscaler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scl2x_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int MAX_W        = 512;
    localparam int MAX_H        = 512;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PHASES  = 9;
    localparam int BIG_ITEMS    = 16;

    typedef enum int {
        IDLE_SEND_LIGHT,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    typedef struct packed {
        t_pix top_left;
        t_pix top_right;
        t_pix bottom_left;
        t_pix bottom_right;
        t_pos src_col;
        t_pos src_row;
        logic last_of_run;
        logic frame_done;
    } t_block;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [APB_W-1:0]  pwdata = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;
    logic              pix_valid = 1'b0;
    logic              o_pixel_ready;
    t_pix              pix_data = '0;
    logic              o_blk_valid;
    logic              i_blk_ready = 1'b0;
    t_pix              o_top_left;
    t_pix              o_top_right;
    t_pix              o_bottom_left;
    t_pix              o_bottom_right;
    t_pos              o_src_col;
    t_pos              o_src_row;
    logic              o_last_of_run;
    logic              o_frame_done;

    t_pix              pixel_queue [$];
    t_block            expected_blocks [$];
    t_pix              line_mem [0:3*MAX_W-1];
    logic [CFG_W-1:0]  cfg_width = WIDTH_RESET;
    logic [CFG_W-1:0]  cfg_height = HEIGHT_RESET;
    int unsigned       next_col = 0;
    int unsigned       next_row = 0;
    t_pix              palette [3];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                error_count = 0;
    int                stall_cycles = 0;

    scale2x_upscaler #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_pixel_valid (pix_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel       (pix_data),
        .o_blk_valid   (o_blk_valid),
        .i_blk_ready   (i_blk_ready),
        .o_top_left    (o_top_left),
        .o_top_right   (o_top_right),
        .o_bottom_left (o_bottom_left),
        .o_bottom_right(o_bottom_right),
        .o_src_col     (o_src_col),
        .o_src_row     (o_src_row),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---- scale2x prediction ----

    function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned cap);
        if (v == '0) return 1;
        if (int'(v) > cap) return cap;
        return int'(v);
    endfunction

    function automatic t_pix pix_at(int unsigned r, int unsigned c);
        return line_mem[(r % 3) * MAX_W + c];
    endfunction

    function automatic t_block scale_block(int unsigned r, int unsigned c,
                                           int unsigned w, int unsigned h);
        t_pix   e;
        t_pix   up;
        t_pix   down;
        t_pix   left;
        t_pix   right;
        t_block blk;
        e     = pix_at(r, c);
        up    = pix_at(r > 0 ? r - 1 : r, c);
        down  = pix_at(r + 1 < h ? r + 1 : r, c);
        left  = pix_at(r, c > 0 ? c - 1 : c);
        right = pix_at(r, c + 1 < w ? c + 1 : c);
        blk.top_left     = (left == up && up != right && left != down) ? left : e;
        blk.top_right    = (up == right && up != left && right != down) ? right : e;
        blk.bottom_left  = (left == down && left != up && down != right) ? left : e;
        blk.bottom_right = (down == right && left != down && up != right) ? right : e;
        blk.src_col      = t_pos'(c);
        blk.src_row      = t_pos'(r);
        blk.last_of_run  = 1'b0;
        blk.frame_done   = (r == h - 1 && c == w - 1);
        return blk;
    endfunction

    function automatic void predict_blocks(t_pix px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        t_block      run [3];
        int          n;
        w = eff_dim(cfg_width, MAX_W);
        h = eff_dim(cfg_height, MAX_H);
        c = next_col;
        r = next_row;
        n = 0;
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        line_mem[(r % 3) * MAX_W + c] = px;
        if (r > 0) begin
            run[n] = scale_block(r - 1, c, w, h);
            n++;
        end
        if (r == h - 1) begin
            if (c > 0) begin
                run[n] = scale_block(r, c - 1, w, h);
                n++;
            end
            if (c == w - 1) begin
                run[n] = scale_block(r, c, w, h);
                n++;
            end
        end
        if (n > 0) run[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) expected_blocks.push_back(run[i]);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        next_col = c;
        next_row = r;
    endfunction

    // ---- checking ----

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
                               t_block at);
        if (got !== want) begin
            report_mismatch($sformatf("block row %0d col %0d %s: got %h, expected %h",
                                      at.src_row, at.src_col, name, got, want));
        end
    endtask

    task automatic check_block(t_block got);
        t_block want;
        if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("unexpected block row %0d col %0d",
                                      got.src_row, got.src_col));
        end else begin
            want = expected_blocks.pop_front();
            check_field("top_left", got.top_left, want.top_left, want);
            check_field("top_right", got.top_right, want.top_right, want);
            check_field("bottom_left", got.bottom_left, want.bottom_left, want);
            check_field("bottom_right", got.bottom_right, want.bottom_right, want);
            check_field("src_col", 32'(got.src_col), 32'(want.src_col), want);
            check_field("src_row", 32'(got.src_row), 32'(want.src_row), want);
            check_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run), want);
            check_field("frame_done", 32'(got.frame_done), 32'(want.frame_done), want);
        end
    endtask

    // ---- pixel driver ----

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (pix_valid && o_pixel_ready) predict_blocks(pix_data);
            if (!pix_valid || o_pixel_ready) begin
                if (pixel_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pix_data  <= pixel_queue.pop_front();
                    pix_valid <= 1'b1;
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // ---- block monitor ----

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_blk_ready <= 1'b0;
        end else begin
            if (o_blk_valid && i_blk_ready) begin
                check_block({o_top_left, o_top_right, o_bottom_left, o_bottom_right,
                             o_src_col, o_src_row, o_last_of_run, o_frame_done});
            end
            i_blk_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---- watchdog ----

    always @(posedge i_clk) begin
        if ((pix_valid && o_pixel_ready) || (o_blk_valid && i_blk_ready) ||
            (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---- register port ----

    function automatic logic [ADDR_W-1:0] reg_addr(logic idx);
        return {idx, 2'b00};
    endfunction

    task automatic reg_read(logic idx, logic [CFG_W-1:0] want);
        logic [APB_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_W'(want)) begin
            report_mismatch($sformatf("register %0d read %h, expected %h",
                                      idx, got, APB_W'(want)));
        end
    endtask

    task automatic reg_write(logic idx, logic [CFG_W-1:0] val);
        logic [APB_W-1:0] data;
        data = $urandom;
        data[CFG_W-1:0] = val;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_width = val;
        else cfg_height = val;
        next_col = 0;
        next_row = 0;
        reg_read(idx, val);
    endtask

    // ---- sequencing ----

    task automatic drain();
        do @(negedge i_clk);
        while (pixel_queue.size() != 0 || pix_valid || expected_blocks.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_frame(logic [CFG_W-1:0] w_val, logic [CFG_W-1:0] h_val);
        drain();
        reg_write(REG_FRAME_WIDTH, w_val);
        reg_write(REG_FRAME_HEIGHT, h_val);
        @(negedge i_clk);
    endtask

    task automatic set_idle(t_idle_mode mode);
        case (mode)
            IDLE_SEND_LIGHT: begin
                send_idle_pct = 26;
                recv_idle_pct = 74;
            end
            IDLE_SEND_HEAVY: begin
                send_idle_pct = 74;
                recv_idle_pct = 26;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // mostly a small palette so the equality rules fire often
    function automatic t_pix next_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return palette[$urandom_range(0, 2)];
        endcase
    endfunction

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) pixel_queue.push_back(next_pixel());
    endtask

    initial begin
        // two 3x3 frames whose centers trip all four corner rules
        t_pix             grids [18] = '{
            32'd7, 32'd1, 32'd7,  32'd1, 32'd3, 32'd2,  32'd7, 32'd2, 32'd7,
            32'd7, 32'd1, 32'd7,  32'd2, 32'd3, 32'd1,  32'd7, 32'd2, 32'd7
        };
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;
        int               area;
        int               n;

        for (int i = 0; i < 3*MAX_W; i++) line_mem[i] = '0;
        for (int i = 0; i < 3; i++) palette[i] = $urandom;
        set_idle(IDLE_SEND_LIGHT);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: first row of a tall frame yields nothing
        reg_read(REG_FRAME_WIDTH, WIDTH_RESET);
        reg_read(REG_FRAME_HEIGHT, HEIGHT_RESET);
        @(negedge i_clk);
        pixel_queue.push_back('1);
        pixel_queue.push_back('0);
        pixel_queue.push_back(32'h5a5a_a5a5);

        set_frame(10'd3, 10'd3);
        foreach (grids[i]) pixel_queue.push_back(grids[i]);

        // zero geometry acts as a single pixel frame
        set_frame(10'd0, 10'd0);
        pixel_queue.push_back('0);
        pixel_queue.push_back('1);
        pixel_queue.push_back(32'h8000_0001);

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_idle(t_idle_mode'(p * 3 / RAND_PHASES));
            for (int i = 0; i < 3; i++) palette[i] = $urandom;
            if (p == 2) begin
                set_frame(10'd1023, 10'd1);
                queue_random(BIG_ITEMS);
            end else if (p == 6) begin
                set_frame(10'd1, 10'd1023);
                queue_random(BIG_ITEMS);
            end else begin
                if ($urandom_range(0, 5) == 0) begin
                    w_val = CFG_W'($urandom_range(7, 40));
                    h_val = CFG_W'($urandom_range(1, 2));
                end else begin
                    w_val = CFG_W'($urandom_range(0, 6));
                    h_val = CFG_W'($urandom_range(0, 4));
                end
                set_frame(w_val, h_val);
                area = eff_dim(w_val, MAX_W) * eff_dim(h_val, MAX_H);
                n = area + $urandom_range(0, area / 2);
                queue_random(n);
            end
        end

        drain();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
